FILE: rtl/core/scle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scle_pkg;

   // payload widths of the two channels
   localparam int KIND_W     = 1;
   localparam int RAW_W      = 8;
   localparam int ACTION_W   = 2;
   localparam int CHAR_W     = 32;
   localparam int POSITION_W = 8;
   localparam int LENGTH_W   = 9;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_SCAN_BYTE     = 1'b0;
   localparam logic [KIND_W-1:0] KIND_LINE_CONSUMED = 1'b1;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYOUT_SELECT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHELL_MODE    = 1'd1;

   localparam int LINE_DEPTH_DEFAULT = 256;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // scan codes with a meaning of their own
   localparam logic [6:0] SC_ESC    = 7'd1;
   localparam logic [6:0] SC_BKSP   = 7'd14;
   localparam logic [6:0] SC_CTRL   = 7'd29;
   localparam logic [6:0] SC_LSHIFT = 7'd42;
   localparam logic [6:0] SC_RSHIFT = 7'd54;
   localparam logic [6:0] SC_ALT    = 7'd56;
   localparam logic [6:0] SC_CAPS   = 7'd58;
   localparam logic [6:0] SC_F1     = 7'd59;
   localparam logic [6:0] SC_F10    = 7'd68;
   localparam logic [6:0] SC_F11    = 7'd87;
   localparam logic [6:0] SC_F12    = 7'd88;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 32'h0000_000A;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 32'h0000_0020;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE   = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_ERASE  = 2'd2,
      ACT_DONE   = 2'd3
   } scle_action_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_CLEAR  = 3'd1,
      CMD_ERASE  = 3'd2,
      CMD_DONE   = 3'd3,
      CMD_APPEND = 3'd4
   } scle_cmd_type;

   typedef struct packed {
      scle_cmd_type      cmd;
      logic [CHAR_W-1:0] char_code;
   } scle_op_type;

   localparam int TAB_LEN = 60;
   localparam int ALT_LEN = 18;

   localparam logic [CHAR_W-1:0] QW_LO [0:TAB_LEN-1] = '{
      32'h00, 32'h00, 32'h31, 32'h32, 32'h33, 32'h34, 32'h35, 32'h36, 32'h37, 32'h38,
      32'h39, 32'h30, 32'h2D, 32'h3D, 32'h08, 32'h09, 32'h71, 32'h77, 32'h65, 32'h72,
      32'h74, 32'h79, 32'h75, 32'h69, 32'h6F, 32'h70, 32'h5B, 32'h5D, 32'h0A, 32'h00,
      32'h61, 32'h73, 32'h64, 32'h66, 32'h67, 32'h68, 32'h6A, 32'h6B, 32'h6C, 32'h3B,
      32'h27, 32'h60, 32'h00, 32'h5C, 32'h7A, 32'h78, 32'h63, 32'h76, 32'h62, 32'h6E,
      32'h6D, 32'h2C, 32'h2E, 32'h2F, 32'h00, 32'h2A, 32'h00, 32'h20, 32'h00, 32'h00
   };

   localparam logic [CHAR_W-1:0] QW_UP [0:TAB_LEN-1] = '{
      32'h00, 32'h00, 32'h21, 32'h40, 32'h23, 32'h24, 32'h25, 32'h5E, 32'h26, 32'h2A,
      32'h28, 32'h29, 32'h5F, 32'h2B, 32'h08, 32'h09, 32'h51, 32'h57, 32'h45, 32'h52,
      32'h54, 32'h59, 32'h55, 32'h49, 32'h4F, 32'h50, 32'h7B, 32'h7D, 32'h0A, 32'h00,
      32'h41, 32'h53, 32'h44, 32'h46, 32'h47, 32'h48, 32'h4A, 32'h4B, 32'h4C, 32'h3A,
      32'h22, 32'h7E, 32'h00, 32'h7C, 32'h5A, 32'h58, 32'h43, 32'h56, 32'h42, 32'h4E,
      32'h4D, 32'h3C, 32'h3E, 32'h3F, 32'h00, 32'h2A, 32'h00, 32'h20, 32'h00, 32'h00
   };

   localparam logic [CHAR_W-1:0] AZ_LO [0:TAB_LEN-1] = '{
      32'h00, 32'h00, 32'h26, 32'h82, 32'h22, 32'h27, 32'h28, 32'h2D, 32'h8A, 32'h5F,
      32'h87, 32'hA0, 32'h29, 32'h3D, 32'h08, 32'h09, 32'h61, 32'h7A, 32'h65, 32'h72,
      32'h74, 32'h79, 32'h75, 32'h69, 32'h6F, 32'h70, 32'h5E, 32'h24, 32'h0A, 32'h00,
      32'h71, 32'h73, 32'h64, 32'h66, 32'h67, 32'h68, 32'h6A, 32'h6B, 32'h6C, 32'h6D,
      32'h00, 32'h60, 32'h00, 32'h2A, 32'h77, 32'h78, 32'h63, 32'h76, 32'h62, 32'h6E,
      32'h2C, 32'h3B, 32'h3A, 32'h21, 32'h00, 32'h2A, 32'h00, 32'h20, 32'h00, 32'h00
   };

   localparam logic [CHAR_W-1:0] AZ_UP [0:TAB_LEN-1] = '{
      32'h00, 32'h00, 32'h31, 32'h32, 32'h33, 32'h34, 32'h35, 32'h36, 32'h37, 32'h38,
      32'h39, 32'h30, 32'h2B, 32'h00, 32'h08, 32'h09, 32'h41, 32'h5A, 32'h45, 32'h52,
      32'h54, 32'h59, 32'h55, 32'h49, 32'h4F, 32'h50, 32'hC2A8, 32'hA3, 32'h0A, 32'h00,
      32'h51, 32'h53, 32'h44, 32'h46, 32'h47, 32'h48, 32'h4A, 32'h4B, 32'h4C, 32'h4D,
      32'h25, 32'hC2B5, 32'h00, 32'h23, 32'h57, 32'h58, 32'h43, 32'h56, 32'h42, 32'h4E,
      32'h3F, 32'h2E, 32'h2F, 32'h00, 32'h00, 32'h2A, 32'h00, 32'h20, 32'h00, 32'h00
   };

   localparam logic [CHAR_W-1:0] AZ_ALT [0:ALT_LEN-1] = '{
      32'h00, 32'hE2809C, 32'hC2B4, 32'h7E, 32'h23, 32'h7B, 32'h5B, 32'h7C, 32'h60,
      32'h5C, 32'h5E, 32'h40, 32'h5D, 32'h7D, 32'hC3A2, 32'hC3A5, 32'hE282AC, 32'hC3A7
   };

endpackage

`default_nettype wire

FILE: rtl/core/scle_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scle_req_if;
   import scle_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [RAW_W-1:0]    raw_byte;

   modport source (output valid, output kind, output raw_byte, input ready);
   modport sink   (input valid, input kind, input raw_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/scle_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scle_rsp_if;
   import scle_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [CHAR_W-1:0]     char_code;
   logic [POSITION_W-1:0] position;
   logic [LENGTH_W-1:0]   line_length;

   modport source (output valid, output action, output char_code, output position,
                   output line_length, input ready);
   modport sink   (input valid, input action, input char_code, input position,
                   input line_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/scle_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scle_front (
   input  wire logic          clock,
   input  wire logic          reset,
   scle_req_if.sink           req_bus,
   input  wire logic          layout_azerty,
   input  wire logic          shell_on,
   input  wire logic          queue_ready,
   output logic               queue_push,
   output scle_pkg::scle_op_type queue_op
);
   import scle_pkg::*;

   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic altgr_ff, altgr_in;

   logic              press;
   logic [6:0]        code;
   logic [CHAR_W-1:0] c_lo, c_up, c_alt, c_sel;
   logic              in_tab, in_alt;

   assign code  = req_bus.raw_byte[6:0];
   assign press = ~req_bus.raw_byte[7];

   assign req_bus.ready = queue_ready;
   assign queue_push    = req_bus.valid & queue_ready;

   // table lookups, out-of-range codes give zero
   assign in_tab = (code < 7'(TAB_LEN));
   assign in_alt = (code < 7'(ALT_LEN));
   assign c_lo  = in_tab ? (layout_azerty ? AZ_LO[code[5:0]] : QW_LO[code[5:0]]) : '0;
   assign c_up  = in_tab ? (layout_azerty ? AZ_UP[code[5:0]] : QW_UP[code[5:0]]) : '0;
   assign c_alt = in_alt ? AZ_ALT[code[4:0]] : '0;

   always_comb begin
      if (shift_ff && caps_ff) begin
         c_sel = c_lo;
      end else if (shift_ff || caps_ff) begin
         c_sel = c_up;
      end else if (altgr_ff) begin
         c_sel = c_alt;
      end else begin
         c_sel = c_lo;
      end
   end

   always_comb begin
      shift_in           = shift_ff;
      caps_in            = caps_ff;
      altgr_in           = altgr_ff;
      queue_op.cmd       = CMD_NONE;
      queue_op.char_code = '0;
      if (req_bus.kind[0]) begin
         queue_op.cmd = CMD_CLEAR;
      end else begin
         unique case (code) inside
            SC_ESC, SC_BKSP: begin
               if (press) queue_op.cmd = CMD_ERASE;
            end
            SC_CTRL, SC_ALT: begin
               altgr_in = press;
            end
            SC_LSHIFT, SC_RSHIFT: begin
               shift_in = press;
            end
            SC_CAPS: begin
               if (press) caps_in = ~caps_ff;
            end
            [SC_F1:SC_F10], SC_F11, SC_F12: begin
            end
            default: begin
               if (press) begin
                  if (shell_on && (c_sel == CHAR_NEWLINE)) begin
                     queue_op.cmd       = CMD_DONE;
                     queue_op.char_code = c_sel;
                  end else if (c_sel != '0) begin
                     queue_op.cmd       = CMD_APPEND;
                     queue_op.char_code = c_sel;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
         altgr_ff <= 1'b0;
      end else if (queue_push) begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
         altgr_ff <= altgr_in;
      end
   end
endmodule

`default_nettype wire

FILE: rtl/core/scle_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module scle_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire scle_pkg::scle_op_type push_op,
   output logic                   not_full,
   input  wire logic              pop,
   output logic                   not_empty,
   output scle_pkg::scle_op_type  head_op
);
   import scle_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   scle_op_type        slot_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_full  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

`default_nettype wire

FILE: rtl/core/scle_back.sv
`timescale 1ns / 1ps
`default_nettype none

module scle_back #(
   parameter int LINE_DEPTH = scle_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   input  wire scle_pkg::scle_op_type op,
   output logic                   op_pop,
   scle_rsp_if.source             rsp_bus
);
   import scle_pkg::*;

   localparam int CNT_W = $clog2(LINE_DEPTH + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  out_valid_ff;
   scle_action_type       action_ff, action_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic [POSITION_W-1:0] pos_ff, pos_in;
   logic [LENGTH_W-1:0]   len_ff;

   logic [CNT_W-1:0]          pos_full;
   logic [CNT_W+LENGTH_W-1:0] pos_ext, len_ext;

   // output register frees up when empty or being taken this cycle
   assign op_pop = op_valid & (~out_valid_ff | rsp_bus.ready);

   always_comb begin
      count_in  = count_ff;
      action_in = ACT_NONE;
      char_in   = '0;
      pos_full  = '0;
      case (op.cmd)
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_ERASE: begin
            // decrement first, the new length is the cleared index
            if (count_ff != '0) begin
               count_in  = count_ff - 1'b1;
               action_in = ACT_ERASE;
               char_in   = CHAR_BLANK;
               pos_full  = count_ff - 1'b1;
            end
         end
         CMD_DONE: begin
            action_in = ACT_DONE;
            char_in   = op.char_code;
         end
         CMD_APPEND: begin
            // dropped once the line is full
            if (count_ff < CNT_W'(LINE_DEPTH)) begin
               count_in  = count_ff + 1'b1;
               action_in = ACT_APPEND;
               char_in   = op.char_code;
               pos_full  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // mask count-wide values to the fixed port widths
   assign pos_ext = {{LENGTH_W{1'b0}}, pos_full};
   assign len_ext = {{LENGTH_W{1'b0}}, count_in};
   assign pos_in  = pos_ext[POSITION_W-1:0];

   always_ff @(posedge clock) begin
      if (op_pop) begin
         action_ff <= action_in;
         char_ff   <= char_in;
         pos_ff    <= pos_in;
         len_ff    <= len_ext[LENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (op_pop) count_ff <= count_in;
         if (op_pop) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.action      = action_ff;
   assign rsp_bus.char_code   = char_ff;
   assign rsp_bus.position    = pos_ff;
   assign rsp_bus.line_length = len_ff;
endmodule

`default_nettype wire

FILE: rtl/core/scan_code_to_char_line_editor_unit.sv
// Set-1 keyboard byte translator with line-length tracking.
//
// req_bus carries one beat per keyboard byte: kind 0 is a raw scan byte
// (bit 7 release, bits 6..0 scan code), kind 1 says the line was consumed
// and the length drops to zero. rsp_bus returns exactly one beat per
// request: action (none/append/erase/line complete), the translated
// character word, the line position touched and the new line length.
// csr_wr_en/csr_index/csr_wdata write layout_select (index 0) and
// shell_mode (index 1); write them only while the block is idle.
//
// Path: a request accepted on req_bus is written into the queue, moves
// to the output register once that register is free, and is valid on
// rsp_bus from then until taken. Throughput is one beat per cycle while
// rsp_bus takes every beat; the front stage (modifier flags, table lookup)
// feeds a two-entry queue, and the back stage (line counter, output
// register) drains it. When rsp_bus stalls the queue fills and req_bus
// ready drops once it holds two beats.
//
// Reset (synchronous): modifier flags and line length clear, queue and
// output register empty, layout_select and shell_mode return to 1.
`timescale 1ns / 1ps
`default_nettype none

module scan_code_to_char_line_editor_unit #(
   parameter int LINE_DEPTH = scle_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   scle_req_if.sink                               req_bus,
   scle_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_wr_en,
   input  wire logic [scle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [scle_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import scle_pkg::*;

   // configuration registers
   logic layout_ff;
   logic shell_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= 1'b1;
         shell_ff  <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LAYOUT_SELECT: layout_ff <= csr_wdata[0];
            CSR_SHELL_MODE:    shell_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // front -> queue -> back
   logic        push, not_full, pop, not_empty;
   scle_op_type push_op, head_op;

   scle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .layout_azerty (layout_ff),
      .shell_on      (shell_ff),
      .queue_ready   (not_full),
      .queue_push    (push),
      .queue_op      (push_op)
   );

   scle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_op   (head_op)
   );

   // back stage owns the line counter and the output register
   scle_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (not_empty),
      .op       (head_op),
      .op_pop   (pop),
      .rsp_bus  (rsp_bus)
   );
endmodule

`default_nettype wire

FILE: dv/line_edit_checker.sv
`timescale 1ns / 1ps

module line_edit_checker
   import scle_pkg::*;
#(
   parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   scle_req_if                    req_mon,
   scle_rsp_if                    rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_beats
);

   localparam int   KEY_TABLE_LEN      = 60;
   localparam int   ALTGR_TABLE_LEN    = 18;

   localparam logic [CHAR_W-1:0] QWERTY_LOWER [0:KEY_TABLE_LEN-1] = '{
      'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38,
      'h39, 'h30, 'h2D, 'h3D, 'h08, 'h09, 'h71, 'h77, 'h65, 'h72,
      'h74, 'h79, 'h75, 'h69, 'h6F, 'h70, 'h5B, 'h5D, 'h0A, 'h00,
      'h61, 'h73, 'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B,
      'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76, 'h62, 'h6E,
      'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00
   };

   localparam logic [CHAR_W-1:0] QWERTY_UPPER [0:KEY_TABLE_LEN-1] = '{
      'h00, 'h00, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5E, 'h26, 'h2A,
      'h28, 'h29, 'h5F, 'h2B, 'h08, 'h09, 'h51, 'h57, 'h45, 'h52,
      'h54, 'h59, 'h55, 'h49, 'h4F, 'h50, 'h7B, 'h7D, 'h0A, 'h00,
      'h41, 'h53, 'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h3A,
      'h22, 'h7E, 'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56, 'h42, 'h4E,
      'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00
   };

   localparam logic [CHAR_W-1:0] AZERTY_LOWER [0:KEY_TABLE_LEN-1] = '{
      'h00, 'h00, 'h26, 'h82, 'h22, 'h27, 'h28, 'h2D, 'h8A, 'h5F,
      'h87, 'hA0, 'h29, 'h3D, 'h08, 'h09, 'h61, 'h7A, 'h65, 'h72,
      'h74, 'h79, 'h75, 'h69, 'h6F, 'h70, 'h5E, 'h24, 'h0A, 'h00,
      'h71, 'h73, 'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h6D,
      'h00, 'h60, 'h00, 'h2A, 'h77, 'h78, 'h63, 'h76, 'h62, 'h6E,
      'h2C, 'h3B, 'h3A, 'h21, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00
   };

   localparam logic [CHAR_W-1:0] AZERTY_UPPER [0:KEY_TABLE_LEN-1] = '{
      'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38,
      'h39, 'h30, 'h2B, 'h00, 'h08, 'h09, 'h41, 'h5A, 'h45, 'h52,
      'h54, 'h59, 'h55, 'h49, 'h4F, 'h50, 'hC2A8, 'hA3, 'h0A, 'h00,
      'h51, 'h53, 'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h4D,
      'h25, 'hC2B5, 'h00, 'h23, 'h57, 'h58, 'h43, 'h56, 'h42, 'h4E,
      'h3F, 'h2E, 'h2F, 'h00, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00
   };

   // AltGr always uses the azerty set, whatever the layout
   localparam logic [CHAR_W-1:0] ALTGR_CHARS [0:ALTGR_TABLE_LEN-1] = '{
      'h00, 'hE2809C, 'hC2B4, 'h7E, 'h23, 'h7B, 'h5B, 'h7C, 'h60, 'h5C,
      'h5E, 'h40, 'h5D, 'h7D, 'hC3A2, 'hC3A5, 'hE282AC, 'hC3A7
   };

   typedef struct packed {
      scle_action_type       action;
      logic [CHAR_W-1:0]     char_code;
      logic [POSITION_W-1:0] position;
      logic [LENGTH_W-1:0]   line_length;
   } line_edit_type;

   line_edit_type expected_edits [$];
   line_edit_type want;
   int            fail_count;

   logic        azerty_on;
   logic        shell_on;
   logic        shift_held;
   logic        caps_on;
   logic        altgr_held;
   int unsigned line_len;

   function automatic logic [CHAR_W-1:0] translate_code(input logic [6:0] code);
      logic [CHAR_W-1:0] ch;
      ch = '0;
      if (shift_held != caps_on) begin
         if (code < KEY_TABLE_LEN)
            ch = azerty_on ? AZERTY_UPPER[code] : QWERTY_UPPER[code];
      end else if (!shift_held && altgr_held) begin
         if (code < ALTGR_TABLE_LEN)
            ch = ALTGR_CHARS[code];
      end else if (code < KEY_TABLE_LEN) begin
         ch = azerty_on ? AZERTY_LOWER[code] : QWERTY_LOWER[code];
      end
      return ch;
   endfunction

   function automatic line_edit_type predict_edit(input logic consumed,
                                                  input logic [7:0] raw);
      line_edit_type     ed;
      logic [6:0]        code;
      logic              pressed;
      logic [CHAR_W-1:0] ch;
      ed.action    = ACT_NONE;
      ed.char_code = '0;
      ed.position  = '0;
      code         = raw[6:0];
      pressed      = !raw[7];
      if (consumed) begin
         line_len = 0;
      end else if (code == SC_ESC || code == SC_BKSP) begin
         // erase: shorten first, the new length is the cleared slot
         if (pressed && line_len != 0) begin
            line_len     = line_len - 1;
            ed.action    = ACT_ERASE;
            ed.char_code = CHAR_BLANK;
            ed.position  = line_len[POSITION_W-1:0];
         end
      end else if (code == SC_CTRL || code == SC_ALT) begin
         altgr_held = pressed;
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
         shift_held = pressed;
      end else if (code == SC_CAPS) begin
         if (pressed)
            caps_on = !caps_on;
      end else if ((code >= SC_F1 && code <= SC_F10) || code == SC_F11 || code == SC_F12) begin
         // function keys do nothing
      end else if (pressed) begin
         ch = translate_code(code);
         if (shell_on && ch == CHAR_NEWLINE) begin
            ed.action    = ACT_DONE;
            ed.char_code = ch;
         end else if (ch != '0 && line_len < LINE_DEPTH) begin
            ed.action    = ACT_APPEND;
            ed.char_code = ch;
            ed.position  = line_len[POSITION_W-1:0];
            line_len     = line_len + 1;
         end
      end
      ed.line_length = line_len[LENGTH_W-1:0];
      return ed;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         azerty_on  = 1'b1;
         shell_on   = 1'b1;
         shift_held = 1'b0;
         caps_on    = 1'b0;
         altgr_held = 1'b0;
         line_len   = 0;
         expected_edits.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_LAYOUT_SELECT)
               azerty_on = csr_wdata[0];
            else if (csr_index == CSR_SHELL_MODE)
               shell_on = csr_wdata[0];
         end
         if (req_mon.valid && req_mon.ready)
            expected_edits.push_back(predict_edit(req_mon.kind == KIND_LINE_CONSUMED,
                                                  req_mon.raw_byte));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_edits.size() == 0) begin
               $error("response beat with nothing expected: action %0d, char_code %h",
                      rsp_mon.action, rsp_mon.char_code);
               fail_count++;
            end else begin
               want = expected_edits.pop_front();
               if (rsp_mon.action !== want.action) begin
                  $error("action: expected %0d, actual %0d", want.action, rsp_mon.action);
                  fail_count++;
               end
               if (rsp_mon.char_code !== want.char_code) begin
                  $error("char_code: expected %h, actual %h", want.char_code,
                         rsp_mon.char_code);
                  fail_count++;
               end
               if (rsp_mon.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position,
                         rsp_mon.position);
                  fail_count++;
               end
               if (rsp_mon.line_length !== want.line_length) begin
                  $error("line_length: expected %0d, actual %0d", want.line_length,
                         rsp_mon.line_length);
                  fail_count++;
               end
            end
         end
      end
      pending_beats <= expected_edits.size();
      error_count   <= fail_count;
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import scle_pkg::*;

   localparam int   LINE_DEPTH     = LINE_DEPTH_DEFAULT;
   localparam int   IDLE_PCT       = 9;       // chance in a hundred of an idle cycle
   localparam int   RANDOM_BEATS   = 50;      // beats per random phase
   localparam int   HOLDOFF_CYCLES = 64;      // long receiver stall
   localparam int   SETTLE_CYCLES  = 8;       // margin once the last response is in
   localparam int   CYCLE_LIMIT    = 200_000;

   localparam logic KEY_PRESSED        = 1'b0;
   localparam logic KEY_RELEASED       = 1'b1;
   localparam logic [6:0] SC_ENTER     = 7'd28;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     pending_beats;

   int idle_pct;
   int holdoff_asked;
   int holdoff_seen;
   int holdoff_left;
   int cycle_count;

   scle_req_if req_bus ();
   scle_rsp_if rsp_bus ();

   scan_code_to_char_line_editor_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // watches both channels and the register port, predicts every response
   line_edit_checker #(.LINE_DEPTH(LINE_DEPTH)) line_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_beats (pending_beats)
   );

   // 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit: well beyond the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response side. Normally drops ready at random; when the stimulus asks
   // for a hold-off it keeps ready low while a countdown from HOLDOFF_CYCLES,
   // kept here, runs out, so the internal queue fills and req ready must fall.
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         rsp_bus.ready <= 1'b0;
         holdoff_left  <= holdoff_left - 1;
      end else if (holdoff_seen != holdoff_asked) begin
         rsp_bus.ready <= 1'b0;
         holdoff_seen  <= holdoff_asked;
         holdoff_left  <= HOLDOFF_CYCLES;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   function automatic logic [7:0] key_press(input logic [6:0] code);
      return {KEY_PRESSED, code};
   endfunction

   function automatic logic [7:0] key_release(input logic [6:0] code);
      return {KEY_RELEASED, code};
   endfunction

   // Offer one beat and hold it until accepted. Entered and left right after
   // a rising edge; valid stays high between back-to-back beats.
   task automatic send_beat(input logic kind, input logic [7:0] raw_byte);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.raw_byte <= raw_byte;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: one cycle with the enable high, then the enable drops before the task returns.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly typing with modifier traffic and erases mixed in; the rest is
   // line-consumed beats, stray releases and arbitrary bytes.
   task automatic send_random_keystroke();
      int unsigned pick;
      logic [6:0]  code;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send_beat(KIND_LINE_CONSUMED, 8'($urandom));
      end else if (pick < 13) begin
         send_beat(KIND_SCAN_BYTE, key_press(($urandom_range(0, 1) == 1) ? SC_ESC : SC_BKSP));
      end else if (pick < 25) begin
         case ($urandom_range(0, 4))
            0: code = SC_LSHIFT;
            1: code = SC_RSHIFT;
            2: code = SC_CTRL;
            3: code = SC_ALT;
            default: code = SC_CAPS;
         endcase
         send_beat(KIND_SCAN_BYTE, ($urandom_range(0, 1) == 1) ? key_release(code)
                                                             : key_press(code));
      end else if (pick < 35) begin
         send_beat(KIND_SCAN_BYTE, 8'($urandom));
      end else if (pick < 43) begin
         send_beat(KIND_SCAN_BYTE, key_release(7'($urandom_range(0, 127))));
      end else begin
         // table range, enter included
         send_beat(KIND_SCAN_BYTE, key_press(7'($urandom_range(2, 57))));
      end
   endtask

   task automatic run_random_phase();
      repeat (RANDOM_BEATS) send_random_keystroke();
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_LAYOUT_SELECT;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_SCAN_BYTE;
      req_bus.raw_byte = '0;
      rsp_bus.ready    = 1'b0;
      idle_pct         = IDLE_PCT;
      holdoff_asked    = 0;
      holdoff_seen     = 0;
      holdoff_left     = 0;
      cycle_count      = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset setting: azerty, shell on.
      send_beat(KIND_LINE_CONSUMED, 8'hFF);            // consume, all raw bits set
      send_beat(KIND_SCAN_BYTE, key_press(7'd16));     // 'a', position 0
      send_beat(KIND_SCAN_BYTE, key_press(7'd3));      // single high byte 0x82
      send_beat(KIND_SCAN_BYTE, key_press(SC_BKSP));   // erase, clears slot 1
      send_beat(KIND_SCAN_BYTE, key_press(SC_ESC));    // erase, clears slot 0
      send_beat(KIND_SCAN_BYTE, key_press(SC_ESC));    // erase on an empty line: nothing
      send_beat(KIND_SCAN_BYTE, key_release(7'd16));   // plain release ignored
      send_beat(KIND_SCAN_BYTE, key_press(SC_CAPS));   // caps on
      send_beat(KIND_SCAN_BYTE, key_release(SC_CAPS)); // caps release ignored
      send_beat(KIND_SCAN_BYTE, key_press(7'd26));     // two-byte uppercase word
      send_beat(KIND_SCAN_BYTE, key_press(SC_LSHIFT)); // shift with caps: lowercase
      send_beat(KIND_SCAN_BYTE, key_press(7'd16));
      send_beat(KIND_SCAN_BYTE, key_release(SC_LSHIFT));
      send_beat(KIND_SCAN_BYTE, key_press(SC_CAPS));   // caps off
      send_beat(KIND_SCAN_BYTE, key_press(SC_CTRL));   // AltGr held
      send_beat(KIND_SCAN_BYTE, key_press(7'd16));     // three-byte AltGr word
      send_beat(KIND_SCAN_BYTE, key_press(7'd18));     // beyond the AltGr table
      send_beat(KIND_SCAN_BYTE, key_release(SC_CTRL));
      send_beat(KIND_SCAN_BYTE, key_press(SC_F1));     // function keys ignored
      send_beat(KIND_SCAN_BYTE, key_press(SC_F12));
      send_beat(KIND_SCAN_BYTE, key_press(7'h7F));     // beyond every table
      send_beat(KIND_SCAN_BYTE, key_press(7'h00));     // empty table entry
      send_beat(KIND_SCAN_BYTE, key_press(SC_ENTER));  // shell mode: line complete
      send_beat(KIND_SCAN_BYTE, key_press(SC_ALT));    // other AltGr code
      send_beat(KIND_SCAN_BYTE, key_press(SC_RSHIFT)); // other shift code
      drain_responses();

      // qwerty, shell on; the receiver holds off while beats keep coming
      write_csr(CSR_LAYOUT_SELECT, 1'b0);
      holdoff_asked <= holdoff_asked + 1;
      run_random_phase();
      drain_responses();

      // qwerty, shell off: newline is appended; no idling on either side
      write_csr(CSR_SHELL_MODE, 1'b0);
      idle_pct <= 0;
      run_random_phase();
      drain_responses();
      idle_pct <= IDLE_PCT;

      // azerty, shell off
      write_csr(CSR_LAYOUT_SELECT, 1'b1);
      run_random_phase();
      drain_responses();

      // azerty, shell on: fill the line past its depth, then complete and erase
      write_csr(CSR_SHELL_MODE, 1'b1);
      send_beat(KIND_LINE_CONSUMED, 8'($urandom));
      send_beat(KIND_SCAN_BYTE, key_release(SC_LSHIFT));
      send_beat(KIND_SCAN_BYTE, key_release(SC_RSHIFT));
      send_beat(KIND_SCAN_BYTE, key_release(SC_CTRL));
      send_beat(KIND_SCAN_BYTE, key_release(SC_ALT));
      // letter row, never empty with shift and AltGr released
      repeat (LINE_DEPTH + 6)
         send_beat(KIND_SCAN_BYTE, key_press(7'($urandom_range(16, 25))));
      send_beat(KIND_SCAN_BYTE, key_press(SC_ENTER));  // completes on a full line
      send_beat(KIND_SCAN_BYTE, key_press(SC_BKSP));   // clears the last slot
      run_random_phase();
      drain_responses();

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
